>>> src/dle_stuffed_frame_builder_macros.svh
// assertion macros used by the frame builder back end (dsfb_back)
`ifndef DLE_STUFFED_FRAME_BUILDER_MACROS_SVH
`define DLE_STUFFED_FRAME_BUILDER_MACROS_SVH

// same-cycle implication
`define DSFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dsfb_pkg.sv
// ----------------------------------------------------------------------------
// dsfb_pkg
// shared constants and types of the stuffed frame builder
// ----------------------------------------------------------------------------
package dsfb_pkg;

  localparam logic [7:0] DLE = 8'h10;
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;

  // one classified payload byte
  typedef struct packed {
    logic       open;
    logic       close;
    logic [7:0] len_byte;
    logic [7:0] data;
    logic [7:0] csum;
  } cmd_t;

  typedef enum logic [9:0] {
    PH_HDR_DLE  = 10'b0000000001,
    PH_HDR_STX  = 10'b0000000010,
    PH_LEN      = 10'b0000000100,
    PH_LEN_DUP  = 10'b0000001000,
    PH_DATA     = 10'b0000010000,
    PH_DATA_DUP = 10'b0000100000,
    PH_SUM      = 10'b0001000000,
    PH_SUM_DUP  = 10'b0010000000,
    PH_TRL_DLE  = 10'b0100000000,
    PH_TRL_ETX  = 10'b1000000000
  } phase_t;

endpackage

>>> src/dsfb_front.sv
// ----------------------------------------------------------------------------
// dsfb_front
// tracks frame state and classifies each accepted payload byte
// ----------------------------------------------------------------------------
module dsfb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     msg_len,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output dsfb_pkg::cmd_t cmd
);

  logic       in_frame;
  logic [7:0] bytes_taken;
  logic [7:0] frame_length;
  logic [7:0] running_sum;

  logic       in_frame_next;
  logic [7:0] bytes_taken_next;
  logic [7:0] frame_length_next;
  logic [7:0] running_sum_next;
  logic       close;
  logic       xfer;

  assign in_ready  = cmd_ready && !rst;
  assign cmd_valid = in_valid;
  assign xfer      = in_valid && cmd_ready;

  always_comb begin
    frame_length_next = in_frame ? frame_length : msg_len;
    bytes_taken_next  = (in_frame ? bytes_taken : 8'd0) + 8'd1;
    running_sum_next  = (in_frame ? running_sum : 8'd0) + data_byte;
    close             = (bytes_taken_next >= frame_length_next);
    in_frame_next     = !close;
  end

  assign cmd.open     = !in_frame;
  assign cmd.close    = close;
  assign cmd.len_byte = msg_len + 8'd2;
  assign cmd.data     = data_byte;
  assign cmd.csum     = running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      bytes_taken  <= 8'd0;
      frame_length <= 8'd0;
      running_sum  <= 8'd0;
    end else if (xfer) begin
      in_frame     <= in_frame_next;
      bytes_taken  <= close ? 8'd0 : bytes_taken_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

>>> src/dsfb_queue.sv
// ----------------------------------------------------------------------------
// dsfb_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module dsfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  dsfb_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dsfb_pkg::cmd_t pop_data
);

  dsfb_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/dsfb_back.sv
// ----------------------------------------------------------------------------
// dsfb_back
// byte sequencer that expands each queued item into stuffed frame bytes
// ----------------------------------------------------------------------------
module dsfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  output logic           head_pop,
  input  dsfb_pkg::cmd_t head,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           frame_end
);

  `include "dle_stuffed_frame_builder_macros.svh"

  dsfb_pkg::phase_t phase;
  dsfb_pkg::phase_t phase_eff;
  dsfb_pkg::phase_t phase_next;
  logic             started;
  logic             emit;
  logic             last;
  logic [7:0]       byte_sel;

  assign emit      = head_valid && (!out_valid || out_ready);
  assign phase_eff = started ? phase
                   : (head.open ? dsfb_pkg::PH_HDR_DLE : dsfb_pkg::PH_DATA);
  assign head_pop  = emit && last;

  always_comb begin
    byte_sel   = dsfb_pkg::DLE;
    phase_next = dsfb_pkg::PH_DATA;
    last       = 1'b0;
    case (phase_eff)
      dsfb_pkg::PH_HDR_DLE: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_HDR_STX;
      end
      dsfb_pkg::PH_HDR_STX: begin
        byte_sel   = dsfb_pkg::STX;
        phase_next = dsfb_pkg::PH_LEN;
      end
      dsfb_pkg::PH_LEN: begin
        byte_sel   = head.len_byte;
        phase_next = (head.len_byte == dsfb_pkg::DLE) ? dsfb_pkg::PH_LEN_DUP
                                                      : dsfb_pkg::PH_DATA;
      end
      dsfb_pkg::PH_LEN_DUP: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_DATA;
      end
      dsfb_pkg::PH_DATA: begin
        byte_sel = head.data;
        if (head.data == dsfb_pkg::DLE) begin
          phase_next = dsfb_pkg::PH_DATA_DUP;
        end else begin
          phase_next = dsfb_pkg::PH_SUM;
          last       = !head.close;
        end
      end
      dsfb_pkg::PH_DATA_DUP: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_SUM;
        last       = !head.close;
      end
      dsfb_pkg::PH_SUM: begin
        byte_sel   = head.csum;
        phase_next = (head.csum == dsfb_pkg::DLE) ? dsfb_pkg::PH_SUM_DUP
                                                  : dsfb_pkg::PH_TRL_DLE;
      end
      dsfb_pkg::PH_SUM_DUP: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_TRL_DLE;
      end
      dsfb_pkg::PH_TRL_DLE: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_TRL_ETX;
      end
      dsfb_pkg::PH_TRL_ETX: begin
        byte_sel   = dsfb_pkg::ETX;
        phase_next = dsfb_pkg::PH_HDR_DLE;
        last       = 1'b1;
      end
      default: begin
        byte_sel   = dsfb_pkg::DLE;
        phase_next = dsfb_pkg::PH_DATA;
        last       = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      phase     <= dsfb_pkg::PH_HDR_DLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        started   <= !last;
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= byte_sel;
      frame_end <= (phase_eff == dsfb_pkg::PH_TRL_ETX);
    end
  end

  // a partly sent item keeps the head of the queue
  `DSFB_ASSERT_IMP(a_started_has_head, started, head_valid, "sequencer lost its item")
  // closing DLE is always followed by ETX of the same item
  `DSFB_ASSERT_NXT(a_trl_order, emit && phase_eff == dsfb_pkg::PH_TRL_DLE,
                   started && phase == dsfb_pkg::PH_TRL_ETX, "trailer out of order")
  // frame end flag only rides on ETX
  `DSFB_ASSERT_IMP(a_end_is_etx, out_valid && frame_end, out_byte == dsfb_pkg::ETX,
                   "frame end on a byte other than ETX")
  // header only starts on an item that opens a frame
  `DSFB_ASSERT_IMP(a_hdr_open, emit && phase_eff == dsfb_pkg::PH_HDR_DLE,
                   head.open && !started, "header on an item inside a frame")

endmodule

>>> src/dle_stuffed_frame_builder.sv
// ----------------------------------------------------------------------------
// dle_stuffed_frame_builder
// DLE/STX/ETX framer with byte stuffing and an additive checksum
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        to block   in_valid / in_ready   data_byte, msg_len
// out       from block out_valid / out_ready out_byte, frame_end
//
// one byte per cycle from the byte sequencer while an item waits and out_ready
// is high; payload DLE bytes are doubled; open and close add up to four each
// a two-entry queue lets input transfers continue while the sequencer works
// out_byte is registered; rst is synchronous and clears frame and queue state
// ----------------------------------------------------------------------------
module dle_stuffed_frame_builder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic [7:0] msg_len,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_end
);

  dsfb_pkg::cmd_t push_cmd;
  dsfb_pkg::cmd_t head_cmd;
  logic           push_valid;
  logic           push_ready;
  logic           head_valid;
  logic           head_pop;

  dsfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .msg_len   (msg_len),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready),
    .cmd       (push_cmd)
  );

  dsfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head_cmd)
  );

  dsfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .frame_end  (frame_end)
  );

endmodule

>>> tb/dle_stuffed_frame_builder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_stuffed_frame_builder_checker
// watches both channels of the frame builder, predicts the stuffed byte
// stream for every input transfer and compares each output transfer in order
// ----------------------------------------------------------------------------
module dle_stuffed_frame_builder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  msg_len,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        frame_end,
  output int unsigned error_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  wire_byte_t wire_bytes_q[$];

  logic       framing;
  logic [7:0] taken_count;
  logic [7:0] latched_len;
  logic [7:0] payload_sum;

  task automatic queue_byte(input logic [7:0] value, input logic last);
    wire_byte_t entry;
    entry.value = value;
    entry.last  = last;
    wire_bytes_q.push_back(entry);
  endtask

  task automatic queue_stuffed(input logic [7:0] value);
    queue_byte(value, 1'b0);
    if (value == dsfb_pkg::DLE) begin
      queue_byte(dsfb_pkg::DLE, 1'b0);
    end
  endtask

  task automatic frame_payload_byte(input logic [7:0] data, input logic [7:0] len);
    logic [7:0] len_byte;
    len_byte = len + 8'd2;
    if (!framing) begin
      framing     = 1'b1;
      latched_len = len;
      taken_count = 8'd0;
      payload_sum = 8'd0;
      queue_byte(dsfb_pkg::DLE, 1'b0);
      queue_byte(dsfb_pkg::STX, 1'b0);
      queue_stuffed(len_byte);
    end
    queue_stuffed(data);
    payload_sum = payload_sum + data;
    taken_count = taken_count + 8'd1;
    if (taken_count >= latched_len) begin
      queue_stuffed(payload_sum);
      queue_byte(dsfb_pkg::DLE, 1'b0);
      queue_byte(dsfb_pkg::ETX, 1'b1);
      framing     = 1'b0;
      taken_count = 8'd0;
    end
  endtask

  always @(posedge clk) begin
    wire_byte_t expected;
    if (rst) begin
      wire_bytes_q.delete();
      framing     = 1'b0;
      taken_count = 8'd0;
      latched_len = 8'd0;
      payload_sum = 8'd0;
      error_count = 0;
      outstanding <= 0;
    end else begin
      // input transfer first so a same-cycle output can see it
      if (in_valid && in_ready) begin
        frame_payload_byte(data_byte, msg_len);
      end
      if (out_valid && out_ready) begin
        if (wire_bytes_q.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected output byte %h end %b", out_byte, frame_end);
          end
          error_count++;
        end else begin
          expected = wire_bytes_q.pop_front();
          if (expected.value !== out_byte || expected.last !== frame_end) begin
            if (error_count < 10) begin
              $display("mismatch: expected byte %h end %b, got byte %h end %b",
                       expected.value, expected.last, out_byte, frame_end);
            end
            error_count++;
          end
        end
      end
      outstanding <= wire_bytes_q.size();
    end
  end

endmodule

>>> tb/dle_stuffed_frame_builder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_stuffed_frame_builder_test
// drives messages of random and edge-case lengths into the frame builder
// with random gaps and output stalls; a checker compares the framed stream
// ----------------------------------------------------------------------------
module dle_stuffed_frame_builder_test;

  localparam int unsigned RANDOM_ITEMS = 130;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic [7:0]  msg_len;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        frame_end;
  int unsigned error_count;
  int unsigned outstanding;
  int unsigned idle_cycles;
  int unsigned items_sent;

  dle_stuffed_frame_builder i_dut (.*);

  dle_stuffed_frame_builder_checker i_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [7:0] pick_data();
    if ($urandom_range(0, 4) == 0) begin
      return dsfb_pkg::DLE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic [7:0] len,
                           input int unsigned gap);
    in_valid  <= 1'b1;
    data_byte <= data;
    msg_len   <= len;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input logic [7:0] len, input logic no_gaps);
    int unsigned count;
    count = (len == 0) ? 1 : len;
    for (int unsigned i = 0; i < count; i++) begin
      send_byte(pick_data(), (i == 0) ? len : 8'($urandom_range(0, 255)),
                no_gaps ? 0 : pick_gap());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // output stalls, with stall-free stretches
  initial begin
    int unsigned roll;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll >= 20) begin
        out_ready <= 1'b0;
        if (roll < 90) begin
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned roll;
    logic [7:0]  len;
    items_sent = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    msg_len   <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero length, payload equal to dle
    send_byte(dsfb_pkg::DLE, 8'd0, 0);
    // single-byte frames at the data extremes
    send_byte(8'hff, 8'd1, 1);
    send_byte(8'h00, 8'd1, 0);
    // checksum equal to dle, length ignored mid-frame
    send_byte(8'h08, 8'd2, 0);
    send_byte(8'h08, 8'hff, 2);
    // length byte equal to dle
    send_message(8'd14, 1'b1);
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        len = 8'($urandom_range(1, 8));
      end else if (roll < 97) begin
        len = 8'($urandom_range(9, 40));
      end else begin
        len = 8'($urandom_range(41, 253));
      end
      if (32'(len) > RANDOM_ITEMS - items_sent) begin
        len = 8'(RANDOM_ITEMS - items_sent);
      end
      send_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end

    // longest length, with the wrapping length byte
    send_message(8'd255, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
